// File: hw/rtl/pkf_pkg.sv
// Shared types and constants for the packed PDU packet FIFO.
// Used by pkf_ctrl, pkf_out_reg and packed_pdu_packet_fifo_top.
`timescale 1ns / 1ps
`default_nettype none

package pkf_pkg;

    // Default size of the byte store
    localparam int STORE_BYTES_DEF = 1024;
    // Header bytes ahead of each payload
    localparam int HDR_BYTES = 6;
    // Payload bytes per word on either channel
    localparam int WORD_BYTES = 8;

    // Request codes
    typedef enum logic [1:0] {
        REQ_APPEND_START = 2'd0,
        REQ_APPEND_DATA  = 2'd1,
        REQ_POP          = 2'd2,
        REQ_NONE         = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_TOO_LONG = 3'd3,
        STS_BUSY     = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR_WR,
        S_DATA_WR,
        S_HDR_RD,
        S_CHECK,
        S_DATA_RD,
        S_WORD_OUT,
        S_RESP
    } fsm_t;

    // One result item
    typedef struct packed {
        status_t     status;
        logic [7:0]  direction;
        logic [7:0]  flags;
        logic [15:0] handle;
        logic [7:0]  link_id;
        logic [7:0]  length;
        logic [63:0] word;
        logic [3:0]  byte_count;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/pkf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pkf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pkf_ctrl.sv
// Request sequencer, ring pointers and byte store of the packet FIFO.
// Depends on pkf_pkg and pkf_ram.
`timescale 1ns / 1ps
`default_nettype none

module pkf_ctrl
    import pkf_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  direction,
    input  wire logic [7:0]  pkt_flags,
    input  wire logic [15:0] pkt_handle,
    input  wire logic [7:0]  link_id,
    input  wire logic [7:0]  pkt_length,
    input  wire logic [63:0] payload_word,
    input  wire logic        out_free,
    output logic             res_load,
    output result_t          res
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int FW = $clog2(STORE_BYTES + 1);

    // Ring increment
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(STORE_BYTES - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Bytes in the next word: min(remaining, 8)
    function automatic logic [3:0] word_len(input logic [7:0] remain);
        logic [3:0] r;
        if (remain >= 8'(WORD_BYTES))
        begin
            r = 4'(WORD_BYTES);
        end
        else
        begin
            r = remain[3:0];
        end
        return r;
    endfunction

    fsm_t          state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    pending_reg, pending_next;
    logic          append_open_reg, append_open_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [3:0]    rcnt_reg, rcnt_next;
    logic          rd_issued_reg, rd_issued_next;

    // Item data, no reset needed
    logic [47:0]   hdr_reg, hdr_next;
    logic [63:0]   word_reg, word_next;
    logic [7:0]    cap_reg, cap_next;
    logic [7:0]    remain_reg, remain_next;
    logic [3:0]    wl_reg, wl_next;
    status_t       sts_reg, sts_next;

    logic          ram_we;
    logic [7:0]    ram_wdata;
    logic          rd_issue;
    logic [7:0]    ram_rdata;
    logic          accept;
    logic [FW:0]   need;
    logic          last_word;

    pkf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (ram_wdata),
        .re    (rd_issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign need      = (FW+1)'(fill_reg) + (FW+1)'(pkt_length) + (FW+1)'(HDR_BYTES);
    assign last_word = (remain_reg == {4'b0000, wl_reg});
    assign ram_wdata = (state_reg == S_HDR_WR) ? hdr_reg[7:0] : word_reg[7:0];

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            fill_reg        <= '0;
            pending_reg     <= '0;
            append_open_reg <= 1'b0;
            cnt_reg         <= '0;
            rcnt_reg        <= '0;
            rd_issued_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            fill_reg        <= fill_next;
            pending_reg     <= pending_next;
            append_open_reg <= append_open_next;
            cnt_reg         <= cnt_next;
            rcnt_reg        <= rcnt_next;
            rd_issued_reg   <= rd_issued_next;
        end
    end

    // Item data registers
    always_ff @(posedge clk)
    begin
        hdr_reg    <= hdr_next;
        word_reg   <= word_next;
        cap_reg    <= cap_next;
        remain_reg <= remain_next;
        wl_reg     <= wl_next;
        sts_reg    <= sts_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        wr_ptr_next      = wr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        fill_next        = fill_reg;
        pending_next     = pending_reg;
        append_open_next = append_open_reg;
        cnt_next         = cnt_reg;
        rcnt_next        = rcnt_reg;
        hdr_next         = hdr_reg;
        word_next        = word_reg;
        cap_next         = cap_reg;
        remain_next      = remain_reg;
        wl_next          = wl_reg;
        sts_next         = sts_reg;
        ram_we           = 1'b0;
        rd_issue         = 1'b0;
        res_load         = 1'b0;
        res              = '0;
        res.status       = sts_reg;
        res.last         = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_APPEND_START:
                        begin
                            if (append_open_reg)
                            begin
                                sts_next   = STS_BUSY;
                                state_next = S_RESP;
                            end
                            else if (need > (FW+1)'(STORE_BYTES))
                            begin
                                sts_next   = STS_FULL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                fill_next = fill_reg + FW'(pkt_length) + FW'(HDR_BYTES);
                                pending_next     = pkt_length;
                                append_open_next = (pkt_length != 8'd0);
                                hdr_next   = {pkt_length, link_id, pkt_handle,
                                              pkt_flags, direction};
                                cnt_next   = '0;
                                state_next = S_HDR_WR;
                            end
                        end
                        REQ_APPEND_DATA:
                        begin
                            if (!append_open_reg)
                            begin
                                sts_next   = STS_BUSY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                word_next  = payload_word;
                                cnt_next   = '0;
                                state_next = S_DATA_WR;
                            end
                        end
                        REQ_POP:
                        begin
                            if (append_open_reg)
                            begin
                                sts_next   = STS_BUSY;
                                state_next = S_RESP;
                            end
                            else if (fill_reg == '0)
                            begin
                                sts_next   = STS_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cap_next    = pkt_length;
                                rd_ptr_next = head_reg;
                                cnt_next    = '0;
                                state_next  = S_HDR_RD;
                            end
                        end
                        default:
                        begin
                            // unknown request: dropped, no result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Write the six header bytes, low byte of the shifter first
            S_HDR_WR:
            begin
                ram_we      = 1'b1;
                wr_ptr_next = ptr_inc(wr_ptr_reg);
                hdr_next    = {8'h00, hdr_reg[47:8]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == 4'(HDR_BYTES - 1))
                begin
                    sts_next   = STS_OK;
                    state_next = S_RESP;
                end
            end

            // Write payload bytes until the word or the packet runs out
            S_DATA_WR:
            begin
                ram_we       = 1'b1;
                wr_ptr_next  = ptr_inc(wr_ptr_reg);
                word_next    = {8'h00, word_reg[63:8]};
                pending_next = pending_reg - 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if ((pending_reg == 8'd1) || (cnt_reg == 4'(WORD_BYTES - 1)))
                begin
                    append_open_next = (pending_reg != 8'd1);
                    sts_next         = STS_OK;
                    state_next       = S_RESP;
                end
            end

            // Read the header; bytes return in the cycle after issue
            S_HDR_RD:
            begin
                if (cnt_reg < 4'(HDR_BYTES))
                begin
                    rd_issue    = 1'b1;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (rd_issued_reg)
                begin
                    hdr_next = {ram_rdata, hdr_reg[47:8]};
                    if (cnt_reg == 4'(HDR_BYTES))
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            // Capacity check, then set up the first word
            S_CHECK:
            begin
                if (hdr_reg[47:40] > cap_reg)
                begin
                    sts_next   = STS_TOO_LONG;
                    state_next = S_RESP;
                end
                else
                begin
                    remain_next = hdr_reg[47:40];
                    wl_next     = word_len(hdr_reg[47:40]);
                    word_next   = '0;
                    cnt_next    = '0;
                    rcnt_next   = '0;
                    state_next  = (hdr_reg[47:40] == 8'd0) ? S_WORD_OUT : S_DATA_RD;
                end
            end

            // Gather one payload word, one byte lane per returned read
            S_DATA_RD:
            begin
                if (cnt_reg < wl_reg)
                begin
                    rd_issue    = 1'b1;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (rd_issued_reg)
                begin
                    word_next[{rcnt_reg[2:0], 3'b000} +: 8] = ram_rdata;
                    rcnt_next = rcnt_reg + 1'b1;
                    if (rcnt_reg + 1'b1 == wl_reg)
                    begin
                        state_next = S_WORD_OUT;
                    end
                end
            end

            // Hand the word to the output register
            S_WORD_OUT:
            begin
                res.status     = STS_OK;
                res.direction  = hdr_reg[7:0];
                res.flags      = hdr_reg[15:8];
                res.handle     = hdr_reg[31:16];
                res.link_id    = hdr_reg[39:32];
                res.length     = hdr_reg[47:40];
                res.word       = word_reg;
                res.byte_count = wl_reg;
                res.last       = last_word;
                if (out_free)
                begin
                    res_load    = 1'b1;
                    remain_next = remain_reg - {4'b0000, wl_reg};
                    if (last_word)
                    begin
                        head_next  = rd_ptr_reg;
                        fill_next  = fill_reg - FW'(hdr_reg[47:40]) - FW'(HDR_BYTES);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        wl_next    = word_len(remain_reg - {4'b0000, wl_reg});
                        word_next  = '0;
                        cnt_next   = '0;
                        rcnt_next  = '0;
                        state_next = S_DATA_RD;
                    end
                end
            end

            // Single status result
            S_RESP:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rd_issued_next = rd_issue;
    end

`ifndef SYNTHESIS
    a_open_matches_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (append_open_reg == (pending_reg != 8'd0)))
        else $error("append flag disagrees with pending byte count");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(STORE_BYTES))
        else $error("fill level beyond store size");

    a_load_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (state_reg == S_RESP || state_reg == S_WORD_OUT))
        else $error("result loaded from a non-result state");

    a_read_return: assert property (@(posedge clk) disable iff (!rst_n)
        rd_issued_reg |-> (state_reg == S_HDR_RD || state_reg == S_DATA_RD))
        else $error("read data returned outside a read state");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/pkf_out_reg.sv
// Output register holding one result item until it is taken.
// Depends on pkf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pkf_out_reg
    import pkf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  result_t      res,
    input  wire logic    out_stall,
    output logic         out_valid,
    output logic         out_free,
    output result_t      res_q
);

    logic    valid_reg, valid_next;
    result_t res_reg, res_next;

    // Free when empty or being taken this cycle
    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign res_q     = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load)
        begin
            valid_next = 1'b1;
            res_next   = res;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_free)
        else $error("result loaded over a held item");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (valid_reg && res_reg == $past(res)))
        else $error("loaded result not presented");

    a_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_stall && !load) |=> !valid_reg)
        else $error("taken item still presented");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/packed_pdu_packet_fifo_top.sv
// Top level of the packed PDU packet FIFO.
// Depends on pkf_pkg, pkf_ctrl, pkf_out_reg (and pkf_ram below pkf_ctrl).
`timescale 1ns / 1ps
`default_nettype none

// Variable-length packet FIFO over a ring of STORE_BYTES bytes in one synchronous RAM
// with one write and one read port, one byte per cycle. One item is worked at a time.
// An append start writes the 6-byte header; an append payload word stores its bytes
// until the word or the packet runs out. A status-only result (full, empty, busy) is
// answered without touching the store. A pop reads the 6-byte header, checks the
// length, then for each word reads its bytes and hands the word over; a pop answered
// too long ends after the check.
// Results sit in an output register, so the next item is taken while the last result
// waits. A request other than a successful pop gives one result; req_type 3 gives none.
module packed_pdu_packet_fifo_top
    import pkf_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  direction,
    input  wire logic [7:0]  pkt_flags,
    input  wire logic [15:0] pkt_handle,
    input  wire logic [7:0]  link_id,
    input  wire logic [7:0]  pkt_length,
    input  wire logic [63:0] payload_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [7:0]       out_direction,
    output logic [7:0]       out_flags,
    output logic [15:0]      out_handle,
    output logic [7:0]       out_link_id,
    output logic [7:0]       out_length,
    output logic [63:0]      out_word,
    output logic [3:0]       byte_count,
    output logic             last
);

    logic    out_free;
    logic    res_load;
    result_t res;
    result_t res_q;

    // Sequencer and byte store
    pkf_ctrl #(
        .STORE_BYTES (STORE_BYTES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .direction    (direction),
        .pkt_flags    (pkt_flags),
        .pkt_handle   (pkt_handle),
        .link_id      (link_id),
        .pkt_length   (pkt_length),
        .payload_word (payload_word),
        .out_free     (out_free),
        .res_load     (res_load),
        .res          (res)
    );

    // Result register
    pkf_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_free  (out_free),
        .res_q     (res_q)
    );

    // Split the result onto the ports
    assign status        = res_q.status;
    assign out_direction = res_q.direction;
    assign out_flags     = res_q.flags;
    assign out_handle    = res_q.handle;
    assign out_link_id   = res_q.link_id;
    assign out_length    = res_q.length;
    assign out_word      = res_q.word;
    assign byte_count    = res_q.byte_count;
    assign last          = res_q.last;

endmodule

`default_nettype wire
